/* sv/csdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_pkg
// Shared codes, constants and types of the console and sector disk port.
// ----------------------------------------------------------------------------
package csdp_pkg;

	localparam int SECTOR_BYTES_DEF = 512;
	localparam int ID_BYTES         = 16;
	localparam int REPLY_BYTES      = 4;

	// item kinds
	localparam logic [2:0] KIND_BUS_RD = 3'd0;
	localparam logic [2:0] KIND_BUS_WR = 3'd1;
	localparam logic [2:0] KIND_FILL   = 3'd2;
	localparam logic [2:0] KIND_FETCH  = 3'd3;
	localparam logic [2:0] KIND_DONE   = 3'd4;

	// bus ports
	localparam logic [1:0] PORT_CONSOLE = 2'd0;
	localparam logic [1:0] PORT_TERM    = 2'd1;
	localparam logic [1:0] PORT_DISK    = 2'd2;
	localparam logic [1:0] PORT_DATA    = 2'd3;

	// disk commands
	localparam logic [7:0] CMD_NOP   = 8'h00;
	localparam logic [7:0] CMD_STAT  = 8'h01;
	localparam logic [7:0] CMD_TYPE  = 8'h02;
	localparam logic [7:0] CMD_CAP   = 8'h03;
	localparam logic [7:0] CMD_CSD   = 8'h04;
	localparam logic [7:0] CMD_RESET = 8'h10;
	localparam logic [7:0] CMD_INIT  = 8'h20;
	localparam logic [7:0] CMD_READ  = 8'h30;
	localparam logic [7:0] CMD_PREP  = 8'h40;
	localparam logic [7:0] CMD_WRITE = 8'h50;
	localparam logic [7:0] CMD_VER   = 8'hF0;

	localparam logic [7:0] ERR_NO_MEDIA = 8'hF7;
	localparam logic [7:0] ERR_IO       = 8'hFA;
	localparam logic [7:0] STS_NO_MEDIA = 8'h40;
	localparam logic [7:0] CON_IN_RDY   = 8'h20;
	localparam logic [7:0] CON_OUT_RDY  = 8'h10;
	localparam logic [7:0] BYTE_NONE    = 8'hFF;

	localparam logic [31:0] VER_WORD = 32'h030E009F;

	// read stream sources
	localparam logic [1:0] SRC_REPLY  = 2'd0;
	localparam logic [1:0] SRC_SECTOR = 2'd1;
	localparam logic [1:0] SRC_ID     = 2'd2;

	// storage requests
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// configuration registers
	localparam logic CFG_MEDIA   = 1'b0;
	localparam logic CFG_SECTORS = 1'b1;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        console_out_valid;
		logic [7:0]  console_out_byte;
		logic        console_take;
		logic [1:0]  storage_request;
		logic [31:0] storage_sector_lba;
		logic [7:0]  buffer_byte;
		logic        mem_rd;
		logic        mem_bb;
	} res_t;

endpackage
`default_nettype wire

/* sv/csdp_secbuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_secbuf
// Sector buffer memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module csdp_secbuf #(
	parameter int DEPTH = csdp_pkg::SECTOR_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

/* sv/csdp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csdp_ctrl
// Register state, command decode and stream pointers; drives the buffer port.
// ----------------------------------------------------------------------------
module csdp_ctrl #(
	parameter int SECTOR_BYTES = csdp_pkg::SECTOR_BYTES_DEF,
	parameter int AW           = $clog2(SECTOR_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [2:0]    kind,
	input  wire logic [1:0]    port,
	input  wire logic [7:0]    data,
	input  wire logic [1:0]    console_ready,
	input  wire logic [7:0]    console_byte,
	input  wire logic [8:0]    sector_index,
	input  wire logic          storage_ok,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [31:0]   cfg_data,
	output csdp_pkg::res_t     res,
	output logic               ram_we,
	output logic               ram_re,
	output logic      [AW-1:0] ram_addr,
	output logic      [7:0]    ram_wdata
);

	localparam int CW = $clog2(SECTOR_BYTES + 1);
	localparam int MW = (AW + 1 > 9) ? AW + 1 : 9;

	logic          media_q;
	logic [31:0]   cap_q;
	logic [7:0]    status_q, status_n;
	logic [7:0]    error_q, error_n;
	logic [7:0]    reply_q [4];
	logic [7:0]    reply_n [4];
	logic [1:0]    rsrc_q, rsrc_n;
	logic [AW-1:0] ridx_q, ridx_n;
	logic [CW-1:0] rrem_q, rrem_n;
	logic          wsec_q, wsec_n;
	logic [AW-1:0] widx_q, widx_n;
	logic [CW-1:0] wrem_q, wrem_n;
	logic [1:0]    pend_q, pend_n;
	logic          we_c, re_c;
	logic [AW-1:0] addr_c;
	logic [MW-1:0] sidx_m;
	logic [AW-1:0] sidx_a;
	logic [31:0]   reply_word;

	// sector index modulo buffer size
	always_comb begin
		sidx_m = MW'(sector_index);
		for (int i = 0; i < 3; i++) begin
			if (sidx_m >= MW'(SECTOR_BYTES)) begin
				sidx_m = sidx_m - MW'(SECTOR_BYTES);
			end
		end
		sidx_a = sidx_m[AW-1:0];
	end

	assign reply_word = {reply_q[3], reply_q[2], reply_q[1], reply_q[0]};

	always_comb begin
		res = '0;
		res.read_data = csdp_pkg::BYTE_NONE;
		status_n = status_q;
		error_n  = error_q;
		reply_n  = reply_q;
		rsrc_n   = rsrc_q;
		ridx_n   = ridx_q;
		rrem_n   = rrem_q;
		wsec_n   = wsec_q;
		widx_n   = widx_q;
		wrem_n   = wrem_q;
		pend_n   = pend_q;
		we_c     = 1'b0;
		re_c     = 1'b0;
		addr_c   = sidx_a;
		case (kind)
			csdp_pkg::KIND_BUS_RD: begin
				case (port)
					csdp_pkg::PORT_CONSOLE: begin
						res.read_data = (console_ready[0] ? csdp_pkg::CON_IN_RDY : 8'h00) |
							(console_ready[1] ? csdp_pkg::CON_OUT_RDY : 8'h00);
					end
					csdp_pkg::PORT_TERM: begin
						res.read_data    = console_byte;
						res.console_take = 1'b1;
					end
					csdp_pkg::PORT_DISK: begin
						res.read_data = status_q;
					end
					default: begin
						if (rrem_q != '0) begin
							if (rsrc_q == csdp_pkg::SRC_SECTOR) begin
								re_c       = 1'b1;
								addr_c     = ridx_q;
								res.mem_rd = 1'b1;
							end else if (rsrc_q == csdp_pkg::SRC_ID) begin
								res.read_data = 8'h00;
							end else begin
								res.read_data = reply_q[ridx_q[1:0]];
							end
							ridx_n = ridx_q + 1'b1;
							rrem_n = rrem_q - 1'b1;
						end
					end
				endcase
			end
			csdp_pkg::KIND_BUS_WR: begin
				case (port)
					csdp_pkg::PORT_TERM: begin
						res.console_out_valid = 1'b1;
						res.console_out_byte  = data;
					end
					csdp_pkg::PORT_DISK: begin
						case (data)
							csdp_pkg::CMD_NOP, csdp_pkg::CMD_RESET: begin
								status_n = '0;
								error_n  = '0;
								rsrc_n   = csdp_pkg::SRC_REPLY;
								ridx_n   = '0;
								rrem_n   = CW'(csdp_pkg::REPLY_BYTES);
								wsec_n   = 1'b0;
								widx_n   = '0;
								wrem_n   = CW'(csdp_pkg::REPLY_BYTES);
							end
							csdp_pkg::CMD_STAT: begin
								reply_n[0] = error_q;
								rsrc_n     = csdp_pkg::SRC_REPLY;
								ridx_n     = '0;
								rrem_n     = CW'(1);
								status_n   = '0;
								error_n    = '0;
							end
							csdp_pkg::CMD_TYPE: begin
								rsrc_n     = csdp_pkg::SRC_REPLY;
								ridx_n     = '0;
								rrem_n     = CW'(1);
								reply_n[0] = {7'd0, media_q};
								status_n   = media_q ? 8'h00 : csdp_pkg::STS_NO_MEDIA;
								error_n    = media_q ? 8'h00 : csdp_pkg::ERR_NO_MEDIA;
							end
							csdp_pkg::CMD_CAP: begin
								reply_n[0] = cap_q[7:0];
								reply_n[1] = cap_q[15:8];
								reply_n[2] = cap_q[23:16];
								reply_n[3] = cap_q[31:24];
								status_n   = '0;
								error_n    = '0;
								rsrc_n     = csdp_pkg::SRC_REPLY;
								ridx_n     = '0;
								rrem_n     = CW'(csdp_pkg::REPLY_BYTES);
							end
							csdp_pkg::CMD_CSD: begin
								rsrc_n   = csdp_pkg::SRC_ID;
								ridx_n   = '0;
								rrem_n   = CW'(csdp_pkg::ID_BYTES);
								status_n = '0;
								error_n  = '0;
							end
							csdp_pkg::CMD_INIT: begin
								status_n = media_q ? 8'h00 : csdp_pkg::STS_NO_MEDIA;
								error_n  = media_q ? 8'h00 : csdp_pkg::ERR_NO_MEDIA;
							end
							csdp_pkg::CMD_READ, csdp_pkg::CMD_WRITE: begin
								status_n = '0;
								error_n  = '0;
								if (!media_q) begin
									error_n = csdp_pkg::ERR_IO;
								end else begin
									res.storage_request = (data == csdp_pkg::CMD_READ) ?
										csdp_pkg::REQ_READ : csdp_pkg::REQ_WRITE;
									res.storage_sector_lba = reply_word;
									pend_n = res.storage_request;
								end
								wsec_n = 1'b0;
								widx_n = '0;
								wrem_n = CW'(csdp_pkg::REPLY_BYTES);
							end
							csdp_pkg::CMD_PREP: begin
								status_n = '0;
								error_n  = '0;
								wsec_n   = 1'b1;
								widx_n   = '0;
								wrem_n   = CW'(SECTOR_BYTES);
								rrem_n   = '0;
							end
							csdp_pkg::CMD_VER: begin
								reply_n[0] = csdp_pkg::VER_WORD[7:0];
								reply_n[1] = csdp_pkg::VER_WORD[15:8];
								reply_n[2] = csdp_pkg::VER_WORD[23:16];
								reply_n[3] = csdp_pkg::VER_WORD[31:24];
								rsrc_n     = csdp_pkg::SRC_REPLY;
								ridx_n     = '0;
								rrem_n     = CW'(csdp_pkg::REPLY_BYTES);
							end
							default: begin
							end
						endcase
					end
					csdp_pkg::PORT_DATA: begin
						if (wrem_q != '0) begin
							if (wsec_q) begin
								we_c   = 1'b1;
								addr_c = widx_q;
							end else begin
								reply_n[widx_q[1:0]] = data;
							end
							widx_n = widx_q + 1'b1;
							wrem_n = wrem_q - 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			csdp_pkg::KIND_FILL: begin
				we_c = 1'b1;
			end
			csdp_pkg::KIND_FETCH: begin
				re_c       = 1'b1;
				res.mem_bb = 1'b1;
			end
			csdp_pkg::KIND_DONE: begin
				if (pend_q != csdp_pkg::REQ_NONE) begin
					if (!storage_ok) begin
						error_n = csdp_pkg::ERR_IO;
					end else if (pend_q == csdp_pkg::REQ_READ) begin
						rsrc_n = csdp_pkg::SRC_SECTOR;
						ridx_n = '0;
						rrem_n = CW'(SECTOR_BYTES);
					end
					pend_n = csdp_pkg::REQ_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = fire & we_c;
	assign ram_re    = fire & re_c;
	assign ram_addr  = addr_c;
	assign ram_wdata = data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			media_q  <= 1'b0;
			cap_q    <= '0;
			status_q <= '0;
			error_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				reply_q[i] <= '0;
			end
			rsrc_q   <= csdp_pkg::SRC_REPLY;
			ridx_q   <= '0;
			rrem_q   <= CW'(csdp_pkg::REPLY_BYTES);
			wsec_q   <= 1'b0;
			widx_q   <= '0;
			wrem_q   <= CW'(csdp_pkg::REPLY_BYTES);
			pend_q   <= csdp_pkg::REQ_NONE;
		end else begin
			if (cfg_we) begin
				if (cfg_index == csdp_pkg::CFG_MEDIA) begin
					media_q <= cfg_data[0];
				end else begin
					cap_q <= cfg_data;
				end
			end
			if (fire) begin
				status_q <= status_n;
				error_q  <= error_n;
				reply_q  <= reply_n;
				rsrc_q   <= rsrc_n;
				ridx_q   <= ridx_n;
				rrem_q   <= rrem_n;
				wsec_q   <= wsec_n;
				widx_q   <= widx_n;
				wrem_q   <= wrem_n;
				pend_q   <= pend_n;
			end
		end
	end

`ifndef ASSERT_OFF
	a_pend_code: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3) else $error("pending op holds an invalid code");
	a_rrem_max: assert property (@(posedge clk) disable iff (!arst_n)
		rrem_q <= CW'(SECTOR_BYTES)) else $error("read count beyond buffer size");
	a_wrem_max: assert property (@(posedge clk) disable iff (!arst_n)
		wrem_q <= CW'(SECTOR_BYTES)) else $error("write count beyond buffer size");
	a_wrem_reply: assert property (@(posedge clk) disable iff (!arst_n)
		!wsec_q |-> wrem_q <= CW'(csdp_pkg::REPLY_BYTES))
		else $error("reply write stream longer than reply buffer");
`endif

endmodule
`default_nettype wire

/* sv/console_and_sector_disk_port_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// console_and_sector_disk_port_core
// Four-port console and sector disk device with a sector buffer memory.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        input      in_valid / in_stall    kind port data console_ready
//                                             console_byte sector_index storage_ok
// out       output     out_valid / out_stall  read_data console_out_* console_take
//                                             storage_request storage_sector_lba
//                                             buffer_byte
// cfg       input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// one item per cycle unless stalled; each makes one result via stage 1 and res_q
// the buffer port gives at most one access per item; its read data lands in stage 1
// state updates at accept, so the next item sees them without an interlock
// in_stall rises only while stage 1 is full and the output register is held
// reset clears all control and register state; the sector buffer is not cleared
// ----------------------------------------------------------------------------
module console_and_sector_disk_port_core #(
	parameter int SECTOR_BYTES = csdp_pkg::SECTOR_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [1:0]  port,
	input  wire logic [7:0]  data,
	input  wire logic [1:0]  console_ready,
	input  wire logic [7:0]  console_byte,
	input  wire logic [8:0]  sector_index,
	input  wire logic        storage_ok,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [7:0]  read_data,
	output logic             console_out_valid,
	output logic      [7:0]  console_out_byte,
	output logic             console_take,
	output logic      [1:0]  storage_request,
	output logic      [31:0] storage_sector_lba,
	output logic      [7:0]  buffer_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(SECTOR_BYTES);

	logic            fire;
	logic            adv_s1;
	logic            vld_s1;
	csdp_pkg::res_t  res_c;
	csdp_pkg::res_t  res_s1;
	csdp_pkg::res_t  res_mem;
	csdp_pkg::res_t  res_q;
	logic            out_vld_q;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_addr;
	logic [7:0]      ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;
	assign adv_s1    = !out_vld_q || !out_stall;
	assign in_stall  = vld_s1 && !adv_s1;
	assign fire      = in_valid && !in_stall;

	csdp_ctrl #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.kind(kind),
		.port(port),
		.data(data),
		.console_ready(console_ready),
		.console_byte(console_byte),
		.sector_index(sector_index),
		.storage_ok(storage_ok),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.res(res_c),
		.ram_we(ram_we),
		.ram_re(ram_re),
		.ram_addr(ram_addr),
		.ram_wdata(ram_wdata)
	);

	csdp_secbuf #(
		.DEPTH(SECTOR_BYTES),
		.AW(AW)
	) u_secbuf (
		.clk(clk),
		.we(ram_we),
		.re(ram_re),
		.addr(ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (!vld_s1 || adv_s1) begin
				vld_s1 <= fire;
			end
			if (adv_s1) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	// merge buffer read data into the stage 1 result
	always_comb begin
		res_mem = res_s1;
		if (res_s1.mem_rd) begin
			res_mem.read_data = ram_rdata;
		end
		if (res_s1.mem_bb) begin
			res_mem.buffer_byte = ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res_c;
		end
		if (adv_s1 && vld_s1) begin
			res_q <= res_mem;
		end
	end

	assign out_valid          = out_vld_q;
	assign read_data          = res_q.read_data;
	assign console_out_valid  = res_q.console_out_valid;
	assign console_out_byte   = res_q.console_out_byte;
	assign console_take       = res_q.console_take;
	assign storage_request    = res_q.storage_request;
	assign storage_sector_lba = res_q.storage_sector_lba;
	assign buffer_byte        = res_q.buffer_byte;

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (!vld_s1 || adv_s1)) else $error("item taken over a held stage");
	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> vld_s1) else $error("taken item lost before stage 1");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s1 && out_vld_q)) else $error("stall without a held result");
`endif

endmodule
`default_nettype wire
